// File: sv/tds_sensor_uart_poll_controller_assert.svh
// Assertion macros for the sensor poll controller checker.
`ifndef TDS_SENSOR_UART_POLL_CONTROLLER_ASSERT_SVH
`define TDS_SENSOR_UART_POLL_CONTROLLER_ASSERT_SVH

// same-cycle implication, clocked on aclk, quiet during reset
`define TSP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("tsp check failed");

// next-cycle implication
`define TSP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("tsp check failed");

`endif

// File: sv/tsp_pkg.sv
// Shared types and constants for the sensor poll controller.
`default_nettype none
package tsp_pkg;

    localparam int REPLY_BYTES   = 11;
    localparam int REQUEST_BYTES = 8;
    localparam logic [7:0] STREAK_MAX = 8'd250;

    localparam logic [7:0] BYTE_SOF      = 8'h55;
    localparam logic [7:0] BYTE_LEN      = 8'h07;
    localparam logic [7:0] OP_READ       = 8'h05;
    localparam logic [7:0] OP_CAL_EC     = 8'h03;
    localparam logic [7:0] OP_CAL_TEMP   = 8'h04;
    localparam logic [7:0] OP_INFO_EC    = 8'h01;
    localparam logic [7:0] OP_INFO_TEMP  = 8'h02;
    localparam logic [7:0] RSP_INFO_EC   = 8'h81;
    localparam logic [7:0] RSP_INFO_TEMP = 8'h82;
    localparam logic [7:0] RSP_ACK_EC    = 8'h83;
    localparam logic [7:0] RSP_ACK_TEMP  = 8'h84;
    localparam logic [7:0] RSP_READ      = 8'h85;
    localparam logic [7:0] INFO_OK       = 8'h01;

    localparam logic [2:0] REG_POLL_INTERVAL = 3'd0;
    localparam logic [2:0] REG_READ_TIMEOUT  = 3'd1;
    localparam logic [2:0] REG_ACK_TIMEOUT   = 3'd2;
    localparam logic [2:0] REG_INFO_TIMEOUT  = 3'd3;
    localparam logic [2:0] REG_CALIB_PAUSE   = 3'd4;
    localparam logic [2:0] REG_CALIB_MAX     = 3'd5;

    typedef enum logic [2:0] {
        PH_IDLE, PH_WAIT_READ, PH_WAIT_ACK, PH_PAUSE, PH_WAIT_INFO
    } phase_t;

    typedef enum logic [1:0] {
        CMD_RX, CMD_TICK, CMD_CAL_EC, CMD_CAL_TEMP
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_TX, KIND_SAMPLE, KIND_CAL_DONE, KIND_REFUSED
    } kind_t;

    // one request's worth of output: a whole frame or a single result
    typedef struct packed {
        logic        is_frame;
        kind_t       kind;
        logic [7:0]  fcmd;
        logic [7:0]  d0;
        logic [7:0]  d1;
        logic [7:0]  d2;
        logic [7:0]  d3;
        logic [1:0]  ch;
        logic [15:0] ec;
        logic [15:0] temp;
        logic        ok;
        logic [7:0]  streak;
        logic        busy;
    } desc_t;

endpackage
`default_nettype wire

// File: sv/tsp_core.sv
// Poll, reply and calibration state machine; one request per cycle while the input handshake is accepted.
`default_nettype none
module tsp_core
    import tsp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        acc,
    input  wire logic [1:0]  command,
    input  wire logic [7:0]  rx_byte,
    input  wire logic [1:0]  channel,
    input  wire logic [15:0] reference_tenths,
    output logic             load,
    output desc_t            desc
);

    logic [15:0] poll_interval_reg, read_timeout_reg, ack_timeout_reg;
    logic [15:0] info_timeout_reg, calib_pause_reg;
    logic [3:0]  calib_max_reg;

    phase_t      phase_reg, phase_next;
    logic        active_reg, active_next, nchan_reg, nchan_next;
    logic [7:0]  rx_store_reg [REPLY_BYTES];
    logic [3:0]  rx_count_reg, rx_count_next;
    logic [7:0]  rx_sum_reg, rx_sum_next;
    logic [15:0] poll_reg, poll_next, wait_reg, wait_next;
    logic [3:0]  att_reg, att_next;
    logic        is_temp_reg, is_temp_next;
    logic [7:0]  streak_reg, streak_next;

    logic        listening, rx_wr, rx_done;
    logic [3:0]  cnt_a;
    logic [7:0]  sum_a;
    logic [15:0] wait_inc, poll_inc;
    logic [3:0]  att_inc;
    logic [1:0]  act_ch;
    logic        busy_now, emit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            poll_interval_reg <= 16'd1000;
            read_timeout_reg  <= 16'd200;
            ack_timeout_reg   <= 16'd500;
            info_timeout_reg  <= 16'd300;
            calib_pause_reg   <= 16'd500;
            calib_max_reg     <= 4'd5;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_POLL_INTERVAL: poll_interval_reg <= cfg_wdata;
                REG_READ_TIMEOUT:  read_timeout_reg  <= cfg_wdata;
                REG_ACK_TIMEOUT:   ack_timeout_reg   <= cfg_wdata;
                REG_INFO_TIMEOUT:  info_timeout_reg  <= cfg_wdata;
                REG_CALIB_PAUSE:   calib_pause_reg   <= cfg_wdata;
                REG_CALIB_MAX:     calib_max_reg     <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    assign listening = (cmd_t'(command) == CMD_RX) &&
        (phase_reg inside {PH_WAIT_READ, PH_WAIT_ACK, PH_WAIT_INFO});
    assign busy_now  = phase_reg inside {PH_WAIT_ACK, PH_PAUSE, PH_WAIT_INFO};
    assign wait_inc  = (wait_reg != 16'hFFFF) ? wait_reg + 16'd1 : wait_reg;
    assign poll_inc  = (poll_reg != 16'hFFFF) ? poll_reg + 16'd1 : poll_reg;
    assign att_inc   = att_reg + 4'd1;
    assign act_ch    = active_reg ? 2'd2 : 2'd1;

    // reply assembly
    always_comb begin
        rx_wr   = 1'b0;
        rx_done = 1'b0;
        cnt_a   = rx_count_reg;
        sum_a   = rx_sum_reg;
        if (listening && !(rx_count_reg == 4'd0 && rx_byte != BYTE_SOF)
            && rx_count_reg < 4'(REPLY_BYTES)) begin
            rx_wr = 1'b1;
            cnt_a = rx_count_reg + 4'd1;
            if (cnt_a < 4'(REPLY_BYTES)) begin
                sum_a = rx_sum_reg + rx_byte;
            end else if (rx_sum_reg != rx_byte) begin
                cnt_a = 4'd0;
                sum_a = 8'd0;
            end else begin
                rx_done = 1'b1;
            end
        end
    end

    always_comb begin
        phase_next    = phase_reg;
        active_next   = active_reg;
        nchan_next    = nchan_reg;
        rx_count_next = cnt_a;
        rx_sum_next   = sum_a;
        poll_next     = poll_reg;
        wait_next     = wait_reg;
        att_next      = att_reg;
        is_temp_next  = is_temp_reg;
        streak_next   = streak_reg;
        emit          = 1'b0;
        desc          = '0;
        desc.ch       = act_ch;
        desc.kind     = KIND_CAL_DONE;

        case (cmd_t'(command))
            CMD_RX: begin
                if (rx_done) begin
                    case (phase_reg)
                        PH_WAIT_READ: begin
                            if (rx_store_reg[2] == RSP_READ) begin
                                streak_next = 8'd0;
                                emit        = 1'b1;
                                desc.kind   = KIND_SAMPLE;
                                desc.ec     = {rx_store_reg[4], rx_store_reg[5]};
                                desc.temp   = {rx_store_reg[6], rx_store_reg[7]};
                            end else if (streak_reg < STREAK_MAX) begin
                                streak_next = streak_reg + 8'd1;
                            end
                            nchan_next = ~active_reg;
                            phase_next = PH_IDLE;
                        end
                        PH_WAIT_ACK: begin
                            if (rx_store_reg[2] ==
                                (is_temp_reg ? RSP_ACK_TEMP : RSP_ACK_EC)) begin
                                att_next   = 4'd0;
                                wait_next  = 16'd0;
                                phase_next = PH_PAUSE;
                            end else begin
                                phase_next = PH_IDLE;
                                emit       = 1'b1;
                            end
                        end
                        default: begin
                            if (rx_store_reg[2] ==
                                (is_temp_reg ? RSP_INFO_TEMP : RSP_INFO_EC)
                                && rx_store_reg[3] == INFO_OK) begin
                                phase_next = PH_IDLE;
                                emit       = 1'b1;
                                desc.ok    = 1'b1;
                            end else begin
                                att_next = att_inc;
                                if (att_inc >= calib_max_reg) begin
                                    phase_next = PH_IDLE;
                                    emit       = 1'b1;
                                end else begin
                                    wait_next  = 16'd0;
                                    phase_next = PH_PAUSE;
                                end
                            end
                        end
                    endcase
                end
            end
            CMD_TICK: begin
                poll_next = poll_inc;
                case (phase_reg)
                    PH_WAIT_READ: begin
                        wait_next = wait_inc;
                        if (wait_inc >= read_timeout_reg) begin
                            if (streak_reg < STREAK_MAX) streak_next = streak_reg + 8'd1;
                            nchan_next = ~active_reg;
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_WAIT_ACK: begin
                        wait_next = wait_inc;
                        if (wait_inc >= ack_timeout_reg) begin
                            phase_next = PH_IDLE;
                            emit       = 1'b1;
                        end
                    end
                    PH_PAUSE: begin
                        wait_next = wait_inc;
                        if (wait_inc >= calib_pause_reg) begin
                            emit          = 1'b1;
                            desc.is_frame = 1'b1;
                            desc.kind     = KIND_TX;
                            desc.fcmd     = is_temp_reg ? OP_INFO_TEMP : OP_INFO_EC;
                            desc.d0       = {6'd0, act_ch};
                            rx_count_next = 4'd0;
                            rx_sum_next   = 8'd0;
                            wait_next     = 16'd0;
                            phase_next    = PH_WAIT_INFO;
                        end
                    end
                    PH_WAIT_INFO: begin
                        wait_next = wait_inc;
                        if (wait_inc >= info_timeout_reg) begin
                            att_next = att_inc;
                            if (att_inc >= calib_max_reg) begin
                                phase_next = PH_IDLE;
                                emit       = 1'b1;
                            end else begin
                                wait_next  = 16'd0;
                                phase_next = PH_PAUSE;
                            end
                        end
                    end
                    default: begin
                        if (poll_inc >= poll_interval_reg) begin
                            poll_next     = 16'd0;
                            active_next   = nchan_reg;
                            emit          = 1'b1;
                            desc.is_frame = 1'b1;
                            desc.kind     = KIND_TX;
                            desc.fcmd     = OP_READ;
                            desc.d0       = nchan_reg ? 8'd2 : 8'd1;
                            rx_count_next = 4'd0;
                            rx_sum_next   = 8'd0;
                            wait_next     = 16'd0;
                            phase_next    = PH_WAIT_READ;
                        end
                    end
                endcase
            end
            default: begin
                emit = 1'b1;
                if (busy_now || channel == 2'd0 || channel == 2'd3) begin
                    desc.kind = KIND_REFUSED;
                    desc.ch   = 2'd0;
                end else begin
                    active_next   = (channel == 2'd2);
                    is_temp_next  = (cmd_t'(command) == CMD_CAL_TEMP);
                    desc.is_frame = 1'b1;
                    desc.kind     = KIND_TX;
                    desc.d0       = {6'd0, channel};
                    if (cmd_t'(command) == CMD_CAL_TEMP) begin
                        desc.fcmd = OP_CAL_TEMP;
                        desc.d1   = reference_tenths[15:8];
                        desc.d2   = reference_tenths[7:0];
                    end else begin
                        desc.fcmd = OP_CAL_EC;
                        desc.d2   = reference_tenths[15:8];
                        desc.d3   = reference_tenths[7:0];
                    end
                    rx_count_next = 4'd0;
                    rx_sum_next   = 8'd0;
                    wait_next     = 16'd0;
                    phase_next    = PH_WAIT_ACK;
                end
            end
        endcase

        if (desc.is_frame) desc.ch = desc.d0[1:0];
        desc.streak = streak_next;
        desc.busy   = phase_next inside {PH_WAIT_ACK, PH_PAUSE, PH_WAIT_INFO};
    end

    assign load = acc && emit;

    always_ff @(posedge aclk) begin
        if (acc && rx_wr) rx_store_reg[rx_count_reg] <= rx_byte;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            active_reg   <= 1'b0;
            nchan_reg    <= 1'b0;
            rx_count_reg <= 4'd0;
            rx_sum_reg   <= 8'd0;
            poll_reg     <= 16'd0;
            wait_reg     <= 16'd0;
            att_reg      <= 4'd0;
            is_temp_reg  <= 1'b0;
            streak_reg   <= 8'd0;
        end else if (acc) begin
            phase_reg    <= phase_next;
            active_reg   <= active_next;
            nchan_reg    <= nchan_next;
            rx_count_reg <= rx_count_next;
            rx_sum_reg   <= rx_sum_next;
            poll_reg     <= poll_next;
            wait_reg     <= wait_next;
            att_reg      <= att_next;
            is_temp_reg  <= is_temp_next;
            streak_reg   <= streak_next;
        end
    end

endmodule
`default_nettype wire

// File: sv/tsp_emit.sv
// Output register: sends a frame byte by byte or a single result.
`default_nettype none
module tsp_emit
    import tsp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        load,
    input  wire desc_t       desc,
    output logic             ready,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,  // tx_byte, sample_channel, ec_tenths,
                                       // temp_tenths, calib_ok, fail_streak, calib_busy
    output logic [1:0]       m_tuser,  // kind
    output logic             m_tlast
);

    logic        busy_reg, busy_next;
    logic [2:0]  beat_reg, beat_next;
    desc_t       desc_reg;
    logic [7:0]  tx, fsum;
    logic        last_beat;

    assign fsum = BYTE_SOF + BYTE_LEN + desc_reg.fcmd + desc_reg.d0 + desc_reg.d1
                + desc_reg.d2 + desc_reg.d3;

    always_comb begin
        case (beat_reg)
            3'd0:    tx = BYTE_SOF;
            3'd1:    tx = BYTE_LEN;
            3'd2:    tx = desc_reg.fcmd;
            3'd3:    tx = desc_reg.d0;
            3'd4:    tx = desc_reg.d1;
            3'd5:    tx = desc_reg.d2;
            3'd6:    tx = desc_reg.d3;
            default: tx = fsum;
        endcase
    end

    assign last_beat = !desc_reg.is_frame || beat_reg == 3'(REQUEST_BYTES - 1);
    assign ready     = !busy_reg || (m_tready && last_beat);

    always_comb begin
        busy_next = busy_reg;
        beat_next = beat_reg;
        if (busy_reg && m_tready) begin
            if (last_beat) busy_next = 1'b0;
            else           beat_next = beat_reg + 3'd1;
        end
        if (load) begin
            busy_next = 1'b1;
            beat_next = 3'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            beat_reg <= 3'd0;
        end else begin
            busy_reg <= busy_next;
            beat_reg <= beat_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) desc_reg <= desc;
    end

    assign m_tvalid = busy_reg;
    assign m_tuser  = desc_reg.kind;
    assign m_tlast  = last_beat;
    assign m_tdata  = {4'd0, desc_reg.busy, desc_reg.streak, desc_reg.ok,
                       desc_reg.temp, desc_reg.ec, desc_reg.ch,
                       desc_reg.is_frame ? tx : 8'd0};

endmodule
`default_nettype wire

// File: sv/tds_sensor_uart_poll_controller.sv
// Top level of the two-channel conductivity sensor poll controller.
// Accepts one request per cycle (link byte, 1 ms tick or calibration start) whenever
// the output register is free or handing over its last result; a request that
// starts a frame holds the input until the frame has drained, one byte per cycle while
// the output port takes it, so the output port sets the rate. Samples, calibration
// outcomes and refusals are a single beat. Configuration writes apply at once.
`default_nettype none
module tds_sensor_uart_poll_controller
    import tsp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,  // rx_byte, channel, reference_tenths
    input  wire logic [1:0]  s_tuser,  // command
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,  // tx_byte, sample_channel, ec_tenths,
                                       // temp_tenths, calib_ok, fail_streak, calib_busy
    output logic [1:0]       m_tuser,  // kind
    output logic             m_tlast
);

    logic  acc, load;
    desc_t desc;

    assign acc = s_tvalid && s_tready;

    tsp_core u_core (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .acc              (acc),
        .command          (s_tuser),
        .rx_byte          (s_tdata[7:0]),
        .channel          (s_tdata[9:8]),
        .reference_tenths (s_tdata[25:10]),
        .load             (load),
        .desc             (desc)
    );

    tsp_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (load),
        .desc     (desc),
        .ready    (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire

// File: sv/tsp_checker.sv
// Port-level checks for the poll controller, bound to the top level.
`default_nettype none
`include "tds_sensor_uart_poll_controller_assert.svh"
module tsp_checker
    import tsp_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [55:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tlast
);

    `TSP_ASSERT_NOW(a_single_last, m_tvalid && kind_t'(m_tuser) != KIND_TX, m_tlast)
    `TSP_ASSERT_NOW(a_streak_cap, m_tvalid, m_tdata[50:43] <= STREAK_MAX)
    `TSP_ASSERT_NOW(a_refused_chan, m_tvalid && kind_t'(m_tuser) == KIND_REFUSED,
                    m_tdata[9:8] == 2'd0)
    `TSP_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind tds_sensor_uart_poll_controller tsp_checker u_tsp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
`default_nettype wire

// File: verif/tb.sv
// Self-checking bench for the conductivity sensor poll controller: state-aware stimulus, checked output.
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import tsp_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        cmd_t        cmd;
        logic [7:0]  b;
        logic [1:0]  ch;
        logic [15:0] rf;
    } req_t;

    typedef struct {
        kind_t       kind;
        logic [7:0]  tx;
        logic        last;
        logic [1:0]  ch;
        logic [15:0] ec;
        logic [15:0] temp;
        logic        ok;
        logic [7:0]  streak;
        logic        busy;
    } out_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    tds_sensor_uart_poll_controller dut (.*);

    req_t pending_reqs[$];
    out_t expected_out[$];
    out_t step_out[$];
    int   errors = 0;
    int   cycles = 0;
    int   n_samples = 0;
    int   n_frames = 0;
    int   n_reqs = 0;

    // mirror of the block
    logic [15:0] r_poll = 16'd1000, r_rd = 16'd200, r_ack = 16'd500;
    logic [15:0] r_info = 16'd300, r_pause = 16'd500;
    logic [3:0]  r_max = 4'd5;
    phase_t      ph = PH_IDLE;
    logic        act_ch = 1'b0, nxt_ch = 1'b0;
    logic [7:0]  rx_buf [REPLY_BYTES];
    logic [3:0]  rx_cnt = '0;
    logic [7:0]  rx_acc = '0;
    logic [15:0] poll_cnt = '0, wait_cnt = '0;
    logic [3:0]  tries = '0;
    logic        cal_temp = 1'b0;
    logic [7:0]  fails = '0;

    task automatic push_out(kind_t k, logic [7:0] tx, logic last, logic [1:0] ch,
                            logic [15:0] ec, logic [15:0] tp, logic ok);
        out_t o;
        o.kind = k; o.tx = tx; o.last = last; o.ch = ch;
        o.ec = ec; o.temp = tp; o.ok = ok; o.streak = '0; o.busy = 1'b0;
        step_out.push_back(o);
    endtask

    task automatic push_frame(logic [7:0] op, logic [7:0] d0, logic [7:0] d1,
                              logic [7:0] d2, logic [7:0] d3);
        logic [7:0] f [REQUEST_BYTES];
        logic [7:0] sum;
        sum = '0;
        f[0] = BYTE_SOF; f[1] = BYTE_LEN; f[2] = op;
        f[3] = d0; f[4] = d1; f[5] = d2; f[6] = d3;
        for (int i = 0; i < REQUEST_BYTES - 1; i++) sum = sum + f[i];
        f[REQUEST_BYTES - 1] = sum;
        for (int i = 0; i < REQUEST_BYTES; i++)
            push_out(KIND_TX, f[i], i == REQUEST_BYTES - 1, d0[1:0], '0, '0, 1'b0);
        n_frames++;
    endtask

    function automatic logic take_rx(logic [7:0] b);
        if (rx_cnt == 0 && b != BYTE_SOF) return 1'b0;
        if (rx_cnt >= REPLY_BYTES) return 1'b0;
        rx_buf[rx_cnt] = b;
        rx_cnt = rx_cnt + 1'b1;
        if (rx_cnt < REPLY_BYTES) begin
            rx_acc = rx_acc + b;
            return 1'b0;
        end
        if (rx_acc != b) begin
            rx_cnt = '0;
            rx_acc = '0;
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic waited(logic [15:0] lim);
        if (wait_cnt != 16'hFFFF) wait_cnt = wait_cnt + 1'b1;
        return wait_cnt >= lim;
    endfunction

    function automatic void bump_fail();
        if (fails < STREAK_MAX) fails = fails + 1'b1;
    endfunction

    function automatic void start_wait(phase_t p);
        rx_cnt = '0; rx_acc = '0; wait_cnt = '0; ph = p;
    endfunction

    task automatic try_failed();
        tries = tries + 1'b1;
        if (tries >= r_max) begin
            ph = PH_IDLE;
            push_out(KIND_CAL_DONE, '0, 1'b1, {1'b0, act_ch} + 2'd1, '0, '0, 1'b0);
        end else begin
            wait_cnt = '0;
            ph = PH_PAUSE;
        end
    endtask

    task automatic predict_outputs(req_t r);
        logic busy;
        logic [7:0] code;
        out_t o;
        busy = ph inside {PH_WAIT_ACK, PH_PAUSE, PH_WAIT_INFO};
        step_out.delete();
        case (r.cmd)
            CMD_RX: begin
                if (ph inside {PH_WAIT_READ, PH_WAIT_ACK, PH_WAIT_INFO} && take_rx(r.b)) begin
                    code = rx_buf[2];
                    if (ph == PH_WAIT_READ) begin
                        if (code == RSP_READ) begin
                            fails = '0;
                            push_out(KIND_SAMPLE, '0, 1'b1, {1'b0, act_ch} + 2'd1,
                                     {rx_buf[4], rx_buf[5]}, {rx_buf[6], rx_buf[7]}, 1'b0);
                            n_samples++;
                        end else begin
                            bump_fail();
                        end
                        nxt_ch = ~act_ch;
                        ph = PH_IDLE;
                    end else if (ph == PH_WAIT_ACK) begin
                        if (code == (cal_temp ? RSP_ACK_TEMP : RSP_ACK_EC)) begin
                            tries = '0; wait_cnt = '0; ph = PH_PAUSE;
                        end else begin
                            ph = PH_IDLE;
                            push_out(KIND_CAL_DONE, '0, 1'b1, {1'b0, act_ch} + 2'd1,
                                     '0, '0, 1'b0);
                        end
                    end else begin
                        if (code == (cal_temp ? RSP_INFO_TEMP : RSP_INFO_EC)
                                && rx_buf[3] == INFO_OK) begin
                            ph = PH_IDLE;
                            push_out(KIND_CAL_DONE, '0, 1'b1, {1'b0, act_ch} + 2'd1,
                                     '0, '0, 1'b1);
                        end else begin
                            try_failed();
                        end
                    end
                end
            end
            CMD_TICK: begin
                if (poll_cnt != 16'hFFFF) poll_cnt = poll_cnt + 1'b1;
                case (ph)
                    PH_WAIT_READ: if (waited(r_rd)) begin
                        bump_fail();
                        nxt_ch = ~act_ch;
                        ph = PH_IDLE;
                    end
                    PH_WAIT_ACK: if (waited(r_ack)) begin
                        ph = PH_IDLE;
                        push_out(KIND_CAL_DONE, '0, 1'b1, {1'b0, act_ch} + 2'd1,
                                 '0, '0, 1'b0);
                    end
                    PH_PAUSE: if (waited(r_pause)) begin
                        push_frame(cal_temp ? OP_INFO_TEMP : OP_INFO_EC,
                                   {7'd0, act_ch} + 8'd1, '0, '0, '0);
                        start_wait(PH_WAIT_INFO);
                    end
                    PH_WAIT_INFO: if (waited(r_info)) try_failed();
                    default: if (poll_cnt >= r_poll) begin
                        poll_cnt = '0;
                        act_ch = nxt_ch;
                        push_frame(OP_READ, {7'd0, act_ch} + 8'd1, '0, '0, '0);
                        start_wait(PH_WAIT_READ);
                    end
                endcase
            end
            default: begin
                if (busy || r.ch == 2'd0 || r.ch == 2'd3) begin
                    push_out(KIND_REFUSED, '0, 1'b1, '0, '0, '0, 1'b0);
                end else begin
                    act_ch = r.ch[0] ? 1'b0 : 1'b1;
                    cal_temp = r.cmd == CMD_CAL_TEMP;
                    if (cal_temp)
                        push_frame(OP_CAL_TEMP, {6'd0, r.ch}, r.rf[15:8], r.rf[7:0], '0);
                    else
                        push_frame(OP_CAL_EC, {6'd0, r.ch}, '0, r.rf[15:8], r.rf[7:0]);
                    start_wait(PH_WAIT_ACK);
                end
            end
        endcase
        busy = ph inside {PH_WAIT_ACK, PH_PAUSE, PH_WAIT_INFO};
        foreach (step_out[i]) begin
            o = step_out[i];
            o.streak = fails;
            o.busy = busy;
            expected_out.push_back(o);
        end
    endtask

    // clock, limit
    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    // sender: bursts and gaps
    logic s_acc = 1'b0;
    int   burst_left = 0;
    int   gap_left = 0;

    always @(negedge aclk) begin
        req_t r;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_acc) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                r = pending_reqs.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {6'd0, r.rf, r.ch, r.b};
                s_tuser <= r.cmd;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 15);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver stall pattern
    int rx_mode = 0;
    int rx_phase = 0;

    always @(negedge aclk) begin
        if ($urandom_range(0, 63) == 0) rx_mode = $urandom_range(0, 2);
        rx_phase++;
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= $urandom_range(0, 1);
            default: m_tready <= (rx_phase % 5) < 2;
        endcase
    end

    // monitor
    always @(posedge aclk) begin
        req_t r;
        out_t e;
        s_acc = 1'b0;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                s_acc = 1'b1;
                r.cmd = cmd_t'(s_tuser);
                r.b = s_tdata[7:0];
                r.ch = s_tdata[9:8];
                r.rf = s_tdata[25:10];
                predict_outputs(r);
            end
            if (m_tvalid && m_tready) begin
                if (expected_out.size() == 0) begin
                    $error("unexpected result kind %0d", m_tuser);
                    errors++;
                end else begin
                    e = expected_out.pop_front();
                    if (m_tuser != e.kind) begin
                        $error("kind exp %0d got %0d", e.kind, m_tuser); errors++;
                    end
                    if (m_tdata[7:0] != e.tx) begin
                        $error("tx_byte exp %0h got %0h", e.tx, m_tdata[7:0]); errors++;
                    end
                    if (m_tlast != e.last) begin
                        $error("last exp %0d got %0d", e.last, m_tlast); errors++;
                    end
                    if (m_tdata[9:8] != e.ch) begin
                        $error("sample_channel exp %0d got %0d", e.ch, m_tdata[9:8]);
                        errors++;
                    end
                    if (m_tdata[25:10] != e.ec) begin
                        $error("ec_tenths exp %0d got %0d", e.ec, m_tdata[25:10]); errors++;
                    end
                    if (m_tdata[41:26] != e.temp) begin
                        $error("temp_tenths exp %0d got %0d", e.temp, m_tdata[41:26]);
                        errors++;
                    end
                    if (m_tdata[42] != e.ok) begin
                        $error("calib_ok exp %0d got %0d", e.ok, m_tdata[42]); errors++;
                    end
                    if (m_tdata[50:43] != e.streak) begin
                        $error("fail_streak exp %0d got %0d", e.streak, m_tdata[50:43]);
                        errors++;
                    end
                    if (m_tdata[51] != e.busy) begin
                        $error("calib_busy exp %0d got %0d", e.busy, m_tdata[51]); errors++;
                    end
                end
            end
        end
    end

    // stimulus helpers
    task automatic queue_req(cmd_t c, logic [7:0] b, logic [1:0] ch, logic [15:0] rf);
        req_t r;
        r.cmd = c; r.b = b; r.ch = ch; r.rf = rf;
        pending_reqs.push_back(r);
        n_reqs++;
    endtask

    task automatic send_ticks(int n);
        for (int i = 0; i < n; i++)
            queue_req(CMD_TICK, 8'($urandom), 2'($urandom), 16'($urandom));
    endtask

    task automatic send_reply(logic [7:0] code, logic [7:0] b3, logic good,
                              logic [15:0] ec, logic [15:0] tp);
        logic [7:0] f [REPLY_BYTES];
        logic [7:0] sum;
        sum = '0;
        f[0] = BYTE_SOF; f[1] = 8'($urandom); f[2] = code; f[3] = b3;
        f[4] = ec[15:8]; f[5] = ec[7:0]; f[6] = tp[15:8]; f[7] = tp[7:0];
        f[8] = 8'($urandom); f[9] = 8'($urandom);
        for (int i = 0; i < REPLY_BYTES - 1; i++) sum = sum + f[i];
        f[REPLY_BYTES - 1] = good ? sum : sum ^ 8'($urandom_range(1, 255));
        for (int i = 0; i < REPLY_BYTES; i++)
            queue_req(CMD_RX, f[i], 2'($urandom), 16'($urandom));
    endtask

    task automatic wait_sent();
        do @(posedge aclk); while (pending_reqs.size() > 0 || s_tvalid);
    endtask

    task automatic wait_quiet();
        wait_sent();
        do @(posedge aclk); while (expected_out.size() > 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        @(negedge aclk);
        cfg_wr_en = 1'b1; cfg_index = idx; cfg_wdata = val;
        case (idx)
            REG_POLL_INTERVAL: r_poll = val;
            REG_READ_TIMEOUT:  r_rd = val;
            REG_ACK_TIMEOUT:   r_ack = val;
            REG_INFO_TIMEOUT:  r_info = val;
            REG_CALIB_PAUSE:   r_pause = val;
            default:           r_max = val[3:0];
        endcase
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic set_regs(logic [15:0] p, logic [15:0] rd, logic [15:0] ak,
                            logic [15:0] inf, logic [15:0] pz, logic [3:0] mx);
        wait_quiet();
        write_reg(REG_POLL_INTERVAL, p);
        write_reg(REG_READ_TIMEOUT, rd);
        write_reg(REG_ACK_TIMEOUT, ak);
        write_reg(REG_INFO_TIMEOUT, inf);
        write_reg(REG_CALIB_PAUSE, pz);
        write_reg(REG_CALIB_MAX, {12'd0, mx});
    endtask

    function automatic int ticks_to(logic [15:0] lim, logic [15:0] cnt);
        int n;
        n = (lim > cnt) ? int'(lim) - int'(cnt) : 1;
        return (n > 40) ? 40 : n;
    endfunction

    task automatic poll_now();
        wait_sent();
        send_ticks(ticks_to(r_poll, poll_cnt));
        wait_sent();
    endtask

    task automatic random_reply(logic [7:0] good_code);
        logic [15:0] ec, tp;
        int pick;
        pick = $urandom_range(0, 9);
        ec = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom);
        tp = ($urandom_range(0, 7) == 0) ? 16'h0000 : 16'($urandom);
        if (pick < 7)
            send_reply(good_code, ($urandom_range(0, 5) == 0) ? 8'($urandom) : INFO_OK,
                       1'b1, ec, tp);
        else if (pick == 7)
            send_reply(good_code, INFO_OK, 1'b0, ec, tp);
        else if (pick == 8)
            send_reply(8'($urandom), 8'($urandom), 1'b1, ec, tp);
        else
            queue_req(CMD_RX, 8'($urandom), 2'($urandom), 16'($urandom));
    endtask

    task automatic random_chunk();
        logic [15:0] lim;
        int pick;
        wait_sent();
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            queue_req($urandom_range(0, 1) ? CMD_CAL_TEMP : CMD_CAL_EC, 8'($urandom),
                      2'($urandom), 16'($urandom));
            return;
        end
        case (ph)
            PH_IDLE: begin
                if (pick < 4)
                    queue_req($urandom_range(0, 1) ? CMD_CAL_TEMP : CMD_CAL_EC,
                              8'($urandom), 2'($urandom_range(1, 2)), 16'($urandom));
                else if (pick < 6)
                    queue_req(CMD_RX, 8'($urandom), 2'($urandom), 16'($urandom));
                else
                    send_ticks(ticks_to(r_poll, poll_cnt));
            end
            PH_PAUSE: send_ticks(ticks_to(r_pause, wait_cnt));
            default: begin
                lim = (ph == PH_WAIT_READ) ? r_rd : (ph == PH_WAIT_ACK) ? r_ack : r_info;
                if (pick < 4)
                    send_ticks(ticks_to(lim, wait_cnt));
                else if (ph == PH_WAIT_READ)
                    random_reply(RSP_READ);
                else if (ph == PH_WAIT_ACK)
                    random_reply(cal_temp ? RSP_ACK_TEMP : RSP_ACK_EC);
                else
                    random_reply(cal_temp ? RSP_INFO_TEMP : RSP_INFO_EC);
            end
        endcase
    endtask

    task automatic random_run(int n);
        int start;
        start = n_reqs;
        while (n_reqs - start < n) random_chunk();
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed
        set_regs(16'd2, 16'd4, 16'd4, 16'd4, 16'd2, 4'd2);
        queue_req(CMD_CAL_EC, 8'h00, 2'd0, 16'h1234);
        queue_req(CMD_CAL_TEMP, 8'hFF, 2'd3, 16'hFFFF);
        queue_req(CMD_RX, BYTE_SOF, 2'd1, 16'd0);
        poll_now();
        queue_req(CMD_RX, 8'h12, 2'd0, 16'd0);
        send_reply(RSP_READ, 8'h00, 1'b1, 16'hFFFF, 16'h0000);
        poll_now();
        send_reply(RSP_READ, 8'h00, 1'b0, 16'h0000, 16'hFFFF);
        send_ticks(4);
        poll_now();
        send_reply(RSP_ACK_EC, 8'h00, 1'b1, 16'd100, 16'd250);
        queue_req(CMD_CAL_EC, 8'h00, 2'd1, 16'hFFFF);
        queue_req(CMD_CAL_TEMP, 8'h00, 2'd2, 16'h0001);
        send_reply(RSP_ACK_EC, 8'h00, 1'b1, 16'd0, 16'd0);
        send_ticks(2);
        send_reply(RSP_INFO_EC, 8'h00, 1'b1, 16'd0, 16'd0);
        send_ticks(2);
        send_reply(RSP_INFO_EC, INFO_OK, 1'b1, 16'd0, 16'd0);
        queue_req(CMD_CAL_TEMP, 8'h00, 2'd2, 16'h0000);
        send_reply(RSP_ACK_EC, 8'h00, 1'b1, 16'd0, 16'd0);
        queue_req(CMD_CAL_TEMP, 8'h00, 2'd2, 16'hABCD);
        send_ticks(4);

        // random phases over several register settings
        set_regs(16'd3, 16'd6, 16'd6, 16'd6, 16'd2, 4'd3);
        random_run(35);
        set_regs(16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 4'd1);
        random_run(30);
        set_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 4'd0);
        random_run(30);
        set_regs(16'd5, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd3, 4'd15);
        random_run(35);
        set_regs(16'd2, 16'd3, 16'd3, 16'd3, 16'd1, 4'd15);
        random_run(30);
        set_regs(16'd20, 16'd10, 16'd10, 16'd10, 16'd5, 4'd4);
        random_run(35);

        wait_quiet();
        $display("%0d requests sent, %0d frames and %0d samples checked over 7 settings",
                 n_reqs, n_frames, n_samples);
        $display("final fail streak %0d, %0d mismatches", fails, errors);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

// File: sim.f
+incdir+sv
sv/tsp_pkg.sv
sv/tsp_core.sv
sv/tsp_emit.sv
sv/tds_sensor_uart_poll_controller.sv
sv/tsp_checker.sv
verif/tb.sv
